### hw/rtl/ultrasonic_ranger_obstacle_confirm_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the obstacle-confirm ranger
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGER_OBSTACLE_CONFIRM_TOP_ASSERT_SVH
`define ULTRASONIC_RANGER_OBSTACLE_CONFIRM_TOP_ASSERT_SVH

// same-cycle implication
`define UROC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uroc assertion failed");

// next-cycle implication
`define UROC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uroc assertion failed");

`endif

### hw/rtl/uroc_pkg.sv
// ----------------------------------------------------------------------------
// uroc_pkg
// Types and fixed constants of the obstacle-confirm ranger.
// ----------------------------------------------------------------------------
package uroc_pkg;

   localparam int unsigned TIMEOUT_W   = 16;
   localparam int unsigned THRESH_W    = 16;
   localparam int unsigned CONFIRM_W   = 8;
   localparam int unsigned INTERVAL_W  = 20;
   localparam int unsigned DIST_W      = 16;
   localparam int unsigned RUN_W       = 8;
   localparam int unsigned CSR_DATA_W  = 20;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned REM_W       = 6;

   localparam logic [TIMEOUT_W-1:0]  TRIG_LOW_LAST  = 16'd1;
   localparam logic [TIMEOUT_W-1:0]  TRIG_HIGH_LAST = 16'd9;
   localparam logic [REM_W:0]        DIST_STEP      = 7'd10;
   localparam logic [REM_W-1:0]      DIST_ROUND     = 6'd29;
   localparam logic [REM_W:0]        DIST_DIV       = 7'd58;
   localparam logic [INTERVAL_W-1:0] WINDOW_MAX     = 20'hFFFFF;

   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST    = 16'd30000;
   localparam logic [THRESH_W-1:0]   THRESH_RST     = 16'd150;
   localparam logic [CONFIRM_W-1:0]  CONFIRM_RST    = 8'd3;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RST   = 20'd50000;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_TRIG_LOW  = 5'b00010,
      PH_TRIG_HIGH = 5'b00100,
      PH_WAIT_RISE = 5'b01000,
      PH_PULSE     = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_VALID   = 2'd0,
      KIND_NO_ECHO = 2'd1,
      KIND_FAULT   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TIMEOUT  = 2'd0,
      CSR_THRESH   = 2'd1,
      CSR_CONFIRM  = 2'd2,
      CSR_INTERVAL = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0]  echo_timeout;
      logic [THRESH_W-1:0]   near_threshold_mm;
      logic [CONFIRM_W-1:0]  confirm_count;
      logic [INTERVAL_W-1:0] interval_us;
   } cfg_type;

   typedef struct packed {
      logic echo_level;
      logic monitor_enable;
      logic restart;
   } req_type;

   typedef struct packed {
      logic              trigger_level;
      logic [DIST_W-1:0] distance_out;
      logic              valid_out;
      logic              stop_out;
      logic [RUN_W-1:0]  near_run_out;
      logic              sample_done;
      kind_type          sample_kind;
   } rsp_type;

endpackage

### hw/rtl/ultrasonic_ranger_obstacle_confirm_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_obstacle_confirm_top
// Ultrasonic time-of-flight ranger with consecutive-near obstacle confirm.
// ----------------------------------------------------------------------------
// Each req item is one microsecond tick of the pin sampler; each tick gives
// exactly one rsp item with the trigger pin level and the current results.
// The block takes one item per clock cycle unless the output stalls: the
// item is captured in an input register, then the tick's step logic (phase
// sequencer, echo counters, near-run update) writes the result register.
// Distance is built up as quotient and remainder while the pulse is timed,
// so the per-tick path is one narrow add and compare. Configuration is
// written through csr_wr_en/csr_index/csr_wdata while no item is in flight.
// ----------------------------------------------------------------------------
`include "ultrasonic_ranger_obstacle_confirm_top_assert.svh"

module ultrasonic_ranger_obstacle_confirm_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_echo_level,
   input  logic                             req_monitor_enable,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_trigger_level,
   output logic [15:0]                      rsp_distance_out,
   output logic                             rsp_valid_out,
   output logic                             rsp_stop_out,
   output logic [7:0]                       rsp_near_run_out,
   output logic                             rsp_sample_done,
   output logic [1:0]                       rsp_sample_kind,
   input  logic                             csr_wr_en,
   input  logic [uroc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uroc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   uroc_pkg::cfg_type cfg;
   uroc_pkg::req_type req_item;
   uroc_pkg::req_type item;
   uroc_pkg::rsp_type result;
   uroc_pkg::rsp_type rsp_item;
   logic              out_free;
   logic              take;

   assign req_item.echo_level     = req_echo_level;
   assign req_item.monitor_enable = req_monitor_enable;
   assign req_item.restart        = req_restart;

   uroc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   uroc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .out_free  (out_free),
      .take      (take),
      .item      (item)
   );

   uroc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (take),
      .item   (item),
      .result (result)
   );

   uroc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .result    (result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_trigger_level = rsp_item.trigger_level;
   assign rsp_distance_out  = rsp_item.distance_out;
   assign rsp_valid_out     = rsp_item.valid_out;
   assign rsp_stop_out      = rsp_item.stop_out;
   assign rsp_near_run_out  = rsp_item.near_run_out;
   assign rsp_sample_done   = rsp_item.sample_done;
   assign rsp_sample_kind   = rsp_item.sample_kind;

   `UROC_ASSERT_IMP(a_stall_only_when_full, !req_ready, rsp_valid && !rsp_ready)
   `UROC_ASSERT_IMP(a_valid_sample_flags,
      rsp_valid && rsp_sample_done && rsp_sample_kind == uroc_pkg::KIND_VALID, rsp_valid_out)
   `UROC_ASSERT_IMP(a_invalid_zero_dist, rsp_valid && !rsp_valid_out, rsp_distance_out == 16'd0)
   `UROC_ASSERT_IMP(a_trigger_not_done, rsp_valid && rsp_trigger_level, !rsp_sample_done)

endmodule

### hw/rtl/uroc_csr.sv
// ----------------------------------------------------------------------------
// uroc_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module uroc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [uroc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uroc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output uroc_pkg::cfg_type               cfg
);

   uroc_pkg::cfg_type cfg_ff;
   uroc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (uroc_pkg::csr_index_type'(csr_index))
            uroc_pkg::CSR_TIMEOUT: begin
               cfg_in.echo_timeout = csr_wdata[uroc_pkg::TIMEOUT_W-1:0];
            end
            uroc_pkg::CSR_THRESH: begin
               cfg_in.near_threshold_mm = csr_wdata[uroc_pkg::THRESH_W-1:0];
            end
            uroc_pkg::CSR_CONFIRM: begin
               cfg_in.confirm_count = csr_wdata[uroc_pkg::CONFIRM_W-1:0];
            end
            uroc_pkg::CSR_INTERVAL: begin
               cfg_in.interval_us = csr_wdata[uroc_pkg::INTERVAL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_timeout      <= uroc_pkg::TIMEOUT_RST;
         cfg_ff.near_threshold_mm <= uroc_pkg::THRESH_RST;
         cfg_ff.confirm_count     <= uroc_pkg::CONFIRM_RST;
         cfg_ff.interval_us       <= uroc_pkg::INTERVAL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/uroc_in_reg.sv
// ----------------------------------------------------------------------------
// uroc_in_reg
// Input register: holds one accepted item until the step logic takes it.
// ----------------------------------------------------------------------------
module uroc_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  uroc_pkg::req_type req_item,
   input  logic              out_free,
   output logic              take,
   output uroc_pkg::req_type item
);

   logic              valid_ff;
   logic              valid_in;
   uroc_pkg::req_type item_ff;

   assign take      = valid_ff && out_free;
   assign req_ready = !valid_ff || out_free;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item = item_ff;

endmodule

### hw/rtl/uroc_core.sv
// ----------------------------------------------------------------------------
// uroc_core
// Per-tick sequencer: trigger timing, echo timing, distance and near run.
// The distance (pulse*10+29)/58 is tracked as quotient and remainder that
// advance with each pulse microsecond, so no divider is needed.
// ----------------------------------------------------------------------------
module uroc_core (
   input  logic              clock,
   input  logic              reset,
   input  uroc_pkg::cfg_type cfg,
   input  logic              step,
   input  uroc_pkg::req_type item,
   output uroc_pkg::rsp_type result
);

   uroc_pkg::phase_type               phase_ff, phase_in;
   logic [uroc_pkg::TIMEOUT_W-1:0]    ptime_ff, ptime_in;
   logic [uroc_pkg::INTERVAL_W-1:0]   wtime_ff, wtime_in;
   logic [uroc_pkg::DIST_W-1:0]       quot_ff, quot_in;
   logic [uroc_pkg::REM_W-1:0]        rem_ff, rem_in;
   logic [uroc_pkg::REM_W:0]          rem_sum;
   logic [uroc_pkg::DIST_W-1:0]       dist_ff, dist_in;
   logic                              valid_ff, valid_in;
   logic [uroc_pkg::RUN_W-1:0]        run_ff, run_in;
   logic                              stop_ff, stop_in;
   logic                              finish;
   uroc_pkg::kind_type                finish_kind;
   logic                              trig;

   always_comb begin
      phase_in    = phase_ff;
      ptime_in    = ptime_ff;
      wtime_in    = wtime_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      rem_sum     = '0;
      dist_in     = dist_ff;
      valid_in    = valid_ff;
      run_in      = run_ff;
      stop_in     = stop_ff;
      finish      = 1'b0;
      finish_kind = uroc_pkg::KIND_VALID;
      trig        = 1'b0;

      if (!item.monitor_enable || item.restart) begin
         // abort and clear phase, timers, distance, run and stop
         phase_in = uroc_pkg::PH_IDLE;
         ptime_in = '0;
         wtime_in = '0;
         dist_in  = '0;
         valid_in = 1'b0;
         run_in   = '0;
         stop_in  = 1'b0;
      end else begin
         if (wtime_ff != uroc_pkg::WINDOW_MAX) begin
            wtime_in = wtime_ff + 1'b1;
         end
         if (phase_ff == uroc_pkg::PH_IDLE && wtime_in >= cfg.interval_us) begin
            wtime_in = '0;
            phase_in = uroc_pkg::PH_TRIG_LOW;
            ptime_in = '0;
         end

         case (phase_in)
            uroc_pkg::PH_TRIG_LOW: begin
               if (ptime_in >= uroc_pkg::TRIG_LOW_LAST) begin
                  phase_in = uroc_pkg::PH_TRIG_HIGH;
                  ptime_in = '0;
               end else begin
                  ptime_in = ptime_in + 1'b1;
               end
            end
            uroc_pkg::PH_TRIG_HIGH: begin
               trig = 1'b1;
               if (ptime_in >= uroc_pkg::TRIG_HIGH_LAST) begin
                  phase_in = uroc_pkg::PH_WAIT_RISE;
                  ptime_in = '0;
               end else begin
                  ptime_in = ptime_in + 1'b1;
               end
            end
            uroc_pkg::PH_WAIT_RISE: begin
               if (item.echo_level) begin
                  // rise tick is the first pulse microsecond, handled below
                  phase_in = uroc_pkg::PH_PULSE;
                  ptime_in = '0;
                  quot_in  = '0;
                  rem_in   = uroc_pkg::DIST_ROUND;
               end else if (ptime_in >= cfg.echo_timeout) begin
                  finish      = 1'b1;
                  finish_kind = uroc_pkg::KIND_NO_ECHO;
               end else begin
                  ptime_in = ptime_in + 1'b1;
               end
            end
            default: begin
            end
         endcase

         if (phase_in == uroc_pkg::PH_PULSE) begin
            if (!item.echo_level) begin
               finish      = 1'b1;
               finish_kind = uroc_pkg::KIND_VALID;
            end else if (ptime_in >= cfg.echo_timeout) begin
               finish      = 1'b1;
               finish_kind = uroc_pkg::KIND_FAULT;
            end else begin
               ptime_in = ptime_in + 1'b1;
               rem_sum  = {1'b0, rem_in} + uroc_pkg::DIST_STEP;
               if (rem_sum >= uroc_pkg::DIST_DIV) begin
                  rem_in  = uroc_pkg::REM_W'(rem_sum - uroc_pkg::DIST_DIV);
                  quot_in = quot_in + 1'b1;
               end else begin
                  rem_in = rem_sum[uroc_pkg::REM_W-1:0];
               end
            end
         end

         if (finish) begin
            phase_in = uroc_pkg::PH_IDLE;
            ptime_in = '0;
            case (finish_kind)
               uroc_pkg::KIND_VALID: begin
                  valid_in = 1'b1;
                  dist_in  = quot_in;
                  if (quot_in <= cfg.near_threshold_mm) begin
                     if (run_ff < cfg.confirm_count) begin
                        run_in = run_ff + 1'b1;
                     end
                     if (run_in >= cfg.confirm_count) begin
                        stop_in = 1'b1;
                     end
                  end else begin
                     run_in  = '0;
                     stop_in = 1'b0;
                  end
               end
               uroc_pkg::KIND_NO_ECHO: begin
                  valid_in = 1'b0;
                  dist_in  = '0;
                  run_in   = '0;
                  stop_in  = 1'b0;
               end
               default: begin
                  // fault keeps the stop hold
                  valid_in = 1'b0;
                  dist_in  = '0;
                  run_in   = '0;
               end
            endcase
         end
      end
   end

   always_comb begin
      result.trigger_level = trig;
      result.distance_out  = dist_in;
      result.valid_out     = valid_in;
      result.stop_out      = stop_in;
      result.near_run_out  = run_in;
      result.sample_done   = finish;
      result.sample_kind   = finish ? finish_kind : uroc_pkg::KIND_VALID;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= uroc_pkg::PH_IDLE;
         ptime_ff <= '0;
         wtime_ff <= '0;
         dist_ff  <= '0;
         valid_ff <= 1'b0;
         run_ff   <= '0;
         stop_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         ptime_ff <= ptime_in;
         wtime_ff <= wtime_in;
         dist_ff  <= dist_in;
         valid_ff <= valid_in;
         run_ff   <= run_in;
         stop_ff  <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

endmodule

### hw/rtl/uroc_out_reg.sv
// ----------------------------------------------------------------------------
// uroc_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module uroc_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  uroc_pkg::rsp_type result,
   output logic              free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output uroc_pkg::rsp_type rsp_item
);

   logic              valid_ff;
   logic              valid_in;
   uroc_pkg::rsp_type item_ff;

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

### bench/ultrasonic_ranger_obstacle_confirm_top_tb.sv
// ----------------------------------------------------------------------------
// Obstacle-confirm ranger testbench
// Sends microsecond ticks with random echo, enable and restart levels through
// the req channel, predicts every rsp item with a cycle-free model of the
// ranger and checks each field.
// A short directed script covers reset behavior and the zero and full-scale
// register settings. Random phases follow, with shaped echo pulses and random
// gaps on both channels.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_obstacle_confirm_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import uroc_pkg::*;

   localparam int unsigned CLK_PERIOD    = 10;
   localparam int unsigned RESET_CYCLES  = 10;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned DRAIN_CYCLES  = 10;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned PHASE_ITEMS   = 75;
   localparam int unsigned HOLD_AFTER    = 140;
   localparam int unsigned HOLD_CYCLES   = 300;

   localparam int unsigned LOW_TICKS   = 2;
   localparam int unsigned HIGH_TICKS  = 10;
   localparam int unsigned MM_SCALE    = 10;
   localparam int unsigned MM_BIAS     = 29;
   localparam int unsigned MM_DIVISOR  = 58;

   localparam rsp_type QUIET_RSP = '0;

   typedef struct packed {
      logic                  csr_write;
      csr_index_type         reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      req_type               tick;
      logic [7:0]            repeat_count;
      logic                  has_want;
      rsp_type               want;
   } script_row_type;

   localparam req_type NO_TICK = '{1'b0, 1'b0, 1'b0};

   // echo, enable, restart
   localparam script_row_type DIRECTED [18] = '{
      '{1'b0, CSR_TIMEOUT,  20'd0,       '{1'b1, 1'b0, 1'b0}, 8'd1,  1'b1, QUIET_RSP},
      '{1'b0, CSR_TIMEOUT,  20'd0,       '{1'b1, 1'b1, 1'b1}, 8'd1,  1'b1, QUIET_RSP},
      '{1'b0, CSR_TIMEOUT,  20'd0,       '{1'b0, 1'b1, 1'b0}, 8'd2,  1'b1, QUIET_RSP},
      '{1'b1, CSR_TIMEOUT,  20'd0,       NO_TICK,             8'd0,  1'b0, QUIET_RSP},
      '{1'b1, CSR_INTERVAL, 20'd0,       NO_TICK,             8'd0,  1'b0, QUIET_RSP},
      '{1'b1, CSR_CONFIRM,  20'd0,       NO_TICK,             8'd0,  1'b0, QUIET_RSP},
      '{1'b1, CSR_THRESH,   20'h0FFFF,   NO_TICK,             8'd0,  1'b0, QUIET_RSP},
      '{1'b0, CSR_TIMEOUT,  20'd0,       '{1'b0, 1'b1, 1'b0}, 8'd12, 1'b0, QUIET_RSP},
      '{1'b0, CSR_TIMEOUT,  20'd0,       '{1'b1, 1'b1, 1'b0}, 8'd1,  1'b0, QUIET_RSP},
      '{1'b1, CSR_TIMEOUT,  20'd1,       NO_TICK,             8'd0,  1'b0, QUIET_RSP},
      '{1'b0, CSR_TIMEOUT,  20'd0,       '{1'b0, 1'b1, 1'b0}, 8'd12, 1'b0, QUIET_RSP},
      '{1'b0, CSR_TIMEOUT,  20'd0,       '{1'b1, 1'b1, 1'b0}, 8'd1,  1'b0, QUIET_RSP},
      '{1'b0, CSR_TIMEOUT,  20'd0,       '{1'b0, 1'b1, 1'b0}, 8'd1,  1'b0, QUIET_RSP},
      '{1'b1, CSR_TIMEOUT,  20'h0FFFF,   NO_TICK,             8'd0,  1'b0, QUIET_RSP},
      '{1'b1, CSR_THRESH,   20'd0,       NO_TICK,             8'd0,  1'b0, QUIET_RSP},
      '{1'b1, CSR_CONFIRM,  20'h000FF,   NO_TICK,             8'd0,  1'b0, QUIET_RSP},
      '{1'b1, CSR_INTERVAL, 20'hFFFFF,   NO_TICK,             8'd0,  1'b0, QUIET_RSP},
      '{1'b0, CSR_TIMEOUT,  20'd0,       '{1'b1, 1'b1, 1'b0}, 8'd2,  1'b0, QUIET_RSP}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_echo_level;
   logic                   req_monitor_enable;
   logic                   req_restart;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_trigger_level;
   logic [15:0]            rsp_distance_out;
   logic                   rsp_valid_out;
   logic                   rsp_stop_out;
   logic [7:0]             rsp_near_run_out;
   logic                   rsp_sample_done;
   logic [1:0]             rsp_sample_kind;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // ranger model state
   cfg_type         cfg_shadow;
   phase_type       rng_phase;
   logic [15:0]     rng_ptime;
   logic [19:0]     rng_window;
   logic [15:0]     rng_dist;
   logic            rng_valid;
   logic [7:0]      rng_run;
   logic            rng_stop;

   // echo pulse shaping for the random part
   logic            echo_planned;
   int unsigned     echo_delay;
   int unsigned     echo_width;

   rsp_type         pending_readings[$];
   int unsigned     mismatch_count = 0;
   int unsigned     sent_count = 0;
   int unsigned     cycle_count = 0;

   ultrasonic_ranger_obstacle_confirm_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_echo_level     (req_echo_level),
      .req_monitor_enable (req_monitor_enable),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_trigger_level  (rsp_trigger_level),
      .rsp_distance_out   (rsp_distance_out),
      .rsp_valid_out      (rsp_valid_out),
      .rsp_stop_out       (rsp_stop_out),
      .rsp_near_run_out   (rsp_near_run_out),
      .rsp_sample_done    (rsp_sample_done),
      .rsp_sample_kind    (rsp_sample_kind),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic void clear_ranger();
      rng_phase  = PH_IDLE;
      rng_ptime  = '0;
      rng_window = '0;
      rng_dist   = '0;
      rng_valid  = 1'b0;
      rng_run    = '0;
      rng_stop   = 1'b0;
   endfunction

   function automatic void close_sample(kind_type kind, logic [15:0] pulse);
      int unsigned mm;
      rng_phase = PH_IDLE;
      rng_ptime = '0;
      if (kind == KIND_VALID) begin
         mm        = (32'(pulse) * MM_SCALE + MM_BIAS) / MM_DIVISOR;
         rng_valid = 1'b1;
         rng_dist  = mm[15:0];
         if (mm <= cfg_shadow.near_threshold_mm) begin
            if (rng_run < cfg_shadow.confirm_count) rng_run = rng_run + 8'd1;
            if (rng_run >= cfg_shadow.confirm_count) rng_stop = 1'b1;
         end else begin
            rng_run  = '0;
            rng_stop = 1'b0;
         end
      end else begin
         rng_valid = 1'b0;
         rng_dist  = '0;
         rng_run   = '0;
         // a fault keeps the stop hold
         if (kind == KIND_NO_ECHO) rng_stop = 1'b0;
      end
   endfunction

   function automatic rsp_type step_ranger(req_type tick);
      rsp_type result;
      result = '0;
      if (!tick.monitor_enable || tick.restart) begin
         clear_ranger();
      end else begin
         if (rng_window != WINDOW_MAX) rng_window = rng_window + 20'd1;
         if (rng_phase == PH_IDLE && rng_window >= cfg_shadow.interval_us) begin
            rng_window = '0;
            rng_phase  = PH_TRIG_LOW;
            rng_ptime  = '0;
         end
         if (rng_phase == PH_TRIG_LOW) begin
            rng_ptime = rng_ptime + 16'd1;
            if (rng_ptime >= LOW_TICKS) begin
               rng_phase = PH_TRIG_HIGH;
               rng_ptime = '0;
            end
         end else if (rng_phase == PH_TRIG_HIGH) begin
            result.trigger_level = 1'b1;
            rng_ptime = rng_ptime + 16'd1;
            if (rng_ptime >= HIGH_TICKS) begin
               rng_phase = PH_WAIT_RISE;
               rng_ptime = '0;
            end
         end else if (rng_phase == PH_WAIT_RISE) begin
            if (tick.echo_level) begin
               rng_phase = PH_PULSE;
               rng_ptime = '0;
            end else if (rng_ptime >= cfg_shadow.echo_timeout) begin
               close_sample(KIND_NO_ECHO, '0);
               result.sample_done = 1'b1;
               result.sample_kind = KIND_NO_ECHO;
            end else begin
               rng_ptime = rng_ptime + 16'd1;
            end
         end
         // the rise tick already counts as the first pulse microsecond
         if (rng_phase == PH_PULSE) begin
            if (!tick.echo_level) begin
               close_sample(KIND_VALID, rng_ptime);
               result.sample_done = 1'b1;
               result.sample_kind = KIND_VALID;
            end else if (rng_ptime >= cfg_shadow.echo_timeout) begin
               close_sample(KIND_FAULT, '0);
               result.sample_done = 1'b1;
               result.sample_kind = KIND_FAULT;
            end else begin
               rng_ptime = rng_ptime + 16'd1;
            end
         end
      end
      result.distance_out = rng_dist;
      result.valid_out    = rng_valid;
      result.stop_out     = rng_stop;
      result.near_run_out = rng_run;
      return result;
   endfunction

   function automatic int unsigned idle_gap(bit quiet);
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Plan one echo pulse per measurement: a low stretch, then a high one,
   // sized around the timeout so that valid, no-echo and fault all occur.
   function automatic logic shape_echo();
      logic        level;
      int unsigned span;
      if (rng_phase == PH_WAIT_RISE || rng_phase == PH_PULSE) begin
         if (!echo_planned) begin
            span         = (cfg_shadow.echo_timeout < 40) ? cfg_shadow.echo_timeout : 40;
            echo_delay   = $urandom_range(0, span + 2);
            echo_width   = $urandom_range(1, span + 2);
            echo_planned = 1'b1;
         end
         if (echo_delay > 0) begin
            level      = 1'b0;
            echo_delay = echo_delay - 1;
         end else if (echo_width > 0) begin
            level      = 1'b1;
            echo_width = echo_width - 1;
         end else begin
            level = 1'b0;
         end
         if ($urandom_range(0, 29) == 0) level = ~level;
      end else begin
         echo_planned = 1'b0;
         level        = ($urandom_range(0, 9) == 0);
      end
      return level;
   endfunction

   // Called at a rising edge; returns at the edge that accepts the item.
   task automatic push_tick(req_type tick, logic has_want, rsp_type want);
      int unsigned gap;
      rsp_type     predicted;
      gap = idle_gap((sent_count / 48) % 4 == 1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_echo_level     <= tick.echo_level;
      req_monitor_enable <= tick.monitor_enable;
      req_restart        <= tick.restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = step_ranger(tick);
      pending_readings.push_back(has_want ? want : predicted);
      sent_count++;
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_TIMEOUT:  cfg_shadow.echo_timeout      = value[TIMEOUT_W-1:0];
         CSR_THRESH:   cfg_shadow.near_threshold_mm = value[THRESH_W-1:0];
         CSR_CONFIRM:  cfg_shadow.confirm_count     = value[CONFIRM_W-1:0];
         CSR_INTERVAL: cfg_shadow.interval_us       = value[INTERVAL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic compare_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // result side: random stalls, one long hold-off to back up the input
   initial begin : result_sink
      int unsigned stall;
      int unsigned results_seen;
      bit          hold_done;
      rsp_type     want;
      stall        = 0;
      results_seen = 0;
      hold_done    = 1'b0;
      rsp_ready    = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_readings.size() == 0) begin
               $display("%0t: result with no item outstanding, expected none, actual 0x%0h",
                        $time, {rsp_trigger_level, rsp_distance_out, rsp_valid_out,
                                rsp_stop_out, rsp_near_run_out, rsp_sample_done,
                                rsp_sample_kind});
               mismatch_count++;
            end else begin
               want = pending_readings.pop_front();
               compare_field("trigger_level", want.trigger_level, rsp_trigger_level);
               compare_field("distance_out",  want.distance_out,  rsp_distance_out);
               compare_field("valid_out",     want.valid_out,     rsp_valid_out);
               compare_field("stop_out",      want.stop_out,      rsp_stop_out);
               compare_field("near_run_out",  want.near_run_out,  rsp_near_run_out);
               compare_field("sample_done",   want.sample_done,   rsp_sample_done);
               compare_field("sample_kind",   want.sample_kind,   rsp_sample_kind);
            end
            results_seen++;
         end
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            stall     = HOLD_CYCLES;
         end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
            stall = idle_gap((results_seen / 40) % 4 == 3);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall = stall - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[ultrasonic_ranger_obstacle_confirm_top] ERROR");
      $finish;
   end

   initial begin : stimulus
      req_type                 tick;
      logic [TIMEOUT_W-1:0]    timeout_val;
      logic [THRESH_W-1:0]     thresh_val;
      logic [CONFIRM_W-1:0]    confirm_val;
      logic [INTERVAL_W-1:0]   interval_val;

      req_valid          = 1'b0;
      req_echo_level     = 1'b0;
      req_monitor_enable = 1'b0;
      req_restart        = 1'b0;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_TIMEOUT;
      csr_wdata          = '0;
      echo_planned       = 1'b0;
      echo_delay         = 0;
      echo_width         = 0;
      cfg_shadow.echo_timeout      = TIMEOUT_RST;
      cfg_shadow.near_threshold_mm = THRESH_RST;
      cfg_shadow.confirm_count     = CONFIRM_RST;
      cfg_shadow.interval_us       = INTERVAL_RST;
      clear_ranger();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].csr_write) begin
            write_reg(DIRECTED[r].reg_index, DIRECTED[r].reg_value);
         end else begin
            repeat (DIRECTED[r].repeat_count)
               push_tick(DIRECTED[r].tick, DIRECTED[r].has_want, DIRECTED[r].want);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin
               // zero timeout and interval: every measurement ends at the first echo tick
               timeout_val  = '0;
               interval_val = '0;
               confirm_val  = '0;
               thresh_val   = 16'($urandom_range(0, 7));
            end
            1: begin
               timeout_val  = 16'($urandom_range(1, 4));
               interval_val = 20'($urandom_range(0, 3));
               confirm_val  = 8'd1;
               thresh_val   = 16'($urandom_range(0, 3));
            end
            RANDOM_PHASES - 1: begin
               timeout_val  = '1;
               interval_val = '0;
               confirm_val  = '1;
               thresh_val   = '1;
            end
            default: begin
               timeout_val  = 16'($urandom_range(6, 30));
               interval_val = 20'($urandom_range(1, 30));
               confirm_val  = 8'($urandom_range(1, 4));
               thresh_val   = 16'($urandom_range(1, 6));
            end
         endcase
         write_reg(CSR_TIMEOUT, CSR_DATA_W'(timeout_val));
         write_reg(CSR_THRESH, CSR_DATA_W'(thresh_val));
         write_reg(CSR_CONFIRM, CSR_DATA_W'(confirm_val));
         write_reg(CSR_INTERVAL, interval_val);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            tick.monitor_enable = ($urandom_range(0, 49) != 0);
            tick.restart        = ($urandom_range(0, 59) == 0);
            tick.echo_level     = shape_echo();
            push_tick(tick, 1'b0, QUIET_RSP);
         end
      end

      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ultrasonic_ranger_obstacle_confirm_top] OK");
      end else begin
         $display("[ultrasonic_ranger_obstacle_confirm_top] ERROR");
      end
      $finish;
   end

endmodule
